// ----- rtl/accumulator_cpu_8bit_step_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the accumulator CPU step block
// Shared clocking and reset handling for the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_CPU_8BIT_STEP_MACROS_SVH
`define ACCUMULATOR_CPU_8BIT_STEP_MACROS_SVH

// Property sampled on the rising clock edge, off while reset is asserted.
`define ACS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Same-cycle implication built on the macro above.
`define ACS_ASSERT_IMP(lbl, ante, cons, msg) \
	`ACS_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- rtl/acs_pkg.sv -----
// ----------------------------------------------------------------------------
// acs_pkg
// Types, codes and sizes shared by the accumulator CPU step block.
// ----------------------------------------------------------------------------
package acs_pkg;

	// Memory geometry.
	localparam int MEM_DEPTH = 4096;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	// Stream widths, padded to whole bytes.
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 80;

	// Command codes.
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_STEP  = 2'd2;

	// Opcodes.
	localparam logic [3:0] OP_LDI = 4'd0;
	localparam logic [3:0] OP_LDM = 4'd1;
	localparam logic [3:0] OP_STR = 4'd2;
	localparam logic [3:0] OP_ADD = 4'd3;
	localparam logic [3:0] OP_SUB = 4'd4;
	localparam logic [3:0] OP_JNZ = 4'd5;
	localparam logic [3:0] OP_SWB = 4'd6;
	localparam logic [3:0] OP_SWC = 4'd7;
	localparam logic [3:0] OP_SWD = 4'd8;
	localparam logic [3:0] OP_SWE = 4'd9;
	localparam logic [3:0] OP_OR  = 4'd10;
	localparam logic [3:0] OP_AND = 4'd11;
	localparam logic [3:0] OP_NOT = 4'd12;
	localparam logic [3:0] OP_SHL = 4'd13;
	localparam logic [3:0] OP_SHR = 4'd14;
	localparam logic [3:0] OP_HLT = 4'd15;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH_HI,
		ST_FETCH_LO,
		ST_LOAD,
		ST_READ,
		ST_RESULT
	} state_t;

	// One input beat, last field in the lowest bits.
	typedef struct packed {
		logic [7:0]        write_data;
		logic [ADDR_W-1:0] address;
		logic [1:0]        command;
	} cmd_item_t;

	// One result beat, last field in the lowest bits.
	typedef struct packed {
		logic [7:0]        read_data;
		logic [11:0]       last_operand;
		logic [3:0]        last_opcode;
		logic              halted;
		logic [ADDR_W-1:0] instr_ptr;
		logic [7:0]        reg_e;
		logic [7:0]        reg_d;
		logic [7:0]        reg_c;
		logic [7:0]        reg_b;
		logic [7:0]        reg_a;
	} result_t;

	// Sequencer handshake toward the top level.
	typedef struct packed {
		logic clearing;
		logic take;
		logic emit;
	} core_ctl_t;

endpackage

// ----- rtl/acs_mem.sv -----
// ----------------------------------------------------------------------------
// acs_mem
// Single-port synchronous byte memory with a registered read port.
// ----------------------------------------------------------------------------
module acs_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [acs_pkg::ADDR_W-1:0] addr,
	input  logic [7:0]                wdata,
	output logic [7:0]                rdata
);
	import acs_pkg::*;

	logic [7:0] mem [MEM_DEPTH];
	logic [7:0] rdata_q;

	// Write port and registered read port share one address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/acs_core.sv -----
// ----------------------------------------------------------------------------
// acs_core
// Sequencer and architectural registers: clears the memory after reset,
// then runs write, read and step commands through the single memory port.
// ----------------------------------------------------------------------------
module acs_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  acs_pkg::cmd_item_t         item,
	input  logic                       item_valid,
	input  logic                       out_free,
	output acs_pkg::core_ctl_t         ctl,
	output acs_pkg::result_t           res,
	output logic                       mem_we,
	output logic [acs_pkg::ADDR_W-1:0] mem_addr,
	output logic [7:0]                 mem_wdata,
	input  logic [7:0]                 mem_rdata
);
	import acs_pkg::*;

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] clr_q;
	logic [7:0]        a_q, b_q, c_q, d_q, e_q;
	logic [ADDR_W-1:0] pc_q;
	logic [15:0]       iw_q;
	logic              halt_q;
	logic [7:0]        hi_q;
	logic [7:0]        rd_q;

	logic [15:0]       fetch_word;
	logic [3:0]        opcode;
	logic [11:0]       operand;
	logic [7:0]        alu;
	logic              step_go;
	logic              clear_done;

	assign fetch_word = {hi_q, mem_rdata};
	assign opcode     = fetch_word[15:12];
	assign operand    = fetch_word[11:0];
	assign step_go    = (item.command == CMD_STEP) && !halt_q;
	assign clear_done = (clr_q == ADDR_W'(MEM_DEPTH - 1));

	// Accumulator result for the register-only opcodes.
	always_comb begin
		alu = a_q;
		case (opcode)
			OP_LDI: alu = fetch_word[7:0];
			OP_ADD: alu = b_q + c_q;
			OP_SUB: alu = b_q - c_q;
			OP_SWB: alu = b_q;
			OP_SWC: alu = c_q;
			OP_SWD: alu = d_q;
			OP_SWE: alu = e_q;
			OP_OR:  alu = b_q | c_q;
			OP_AND: alu = b_q & c_q;
			OP_NOT: alu = ~b_q;
			OP_SHL: alu = (|c_q[7:3]) ? 8'd0 : (b_q << c_q[2:0]);
			OP_SHR: alu = (|c_q[7:3]) ? 8'd0 : (b_q >> c_q[2:0]);
			default: alu = a_q;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (item_valid) begin
					if (item.command == CMD_READ) state_d = ST_READ;
					else if (step_go)             state_d = ST_FETCH_HI;
					else                          state_d = ST_RESULT;
				end
			end
			ST_FETCH_HI: state_d = ST_FETCH_LO;
			ST_FETCH_LO: state_d = (opcode == OP_LDM) ? ST_LOAD : ST_RESULT;
			ST_LOAD:     state_d = ST_RESULT;
			ST_READ:     state_d = ST_RESULT;
			ST_RESULT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Memory port and handshake outputs.
	always_comb begin
		mem_we       = 1'b0;
		mem_addr     = pc_q;
		mem_wdata    = a_q;
		ctl.clearing = 1'b0;
		ctl.take     = 1'b0;
		ctl.emit     = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ctl.clearing = 1'b1;
				mem_we       = 1'b1;
				mem_addr     = clr_q;
				mem_wdata    = 8'd0;
			end
			ST_IDLE: begin
				ctl.take = item_valid;
				if (item.command == CMD_WRITE || item.command == CMD_READ) begin
					mem_addr = item.address;
				end
				if (item_valid && item.command == CMD_WRITE) begin
					mem_we    = 1'b1;
					mem_wdata = item.write_data;
				end
			end
			ST_FETCH_HI: mem_addr = pc_q + ADDR_W'(1);
			ST_FETCH_LO: begin
				mem_addr = operand[ADDR_W-1:0];
				mem_we   = (opcode == OP_STR);
			end
			ST_LOAD, ST_READ: mem_addr = pc_q;
			ST_RESULT: ctl.emit = out_free;
			default: mem_addr = pc_q;
		endcase
	end

	// Sequencer state and clear counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
		end
	end

	// Architectural registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			c_q    <= '0;
			d_q    <= '0;
			e_q    <= '0;
			pc_q   <= '0;
			iw_q   <= '0;
			halt_q <= 1'b0;
			rd_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) rd_q <= '0;
				end
				ST_READ: rd_q <= mem_rdata;
				ST_LOAD: a_q <= mem_rdata;
				ST_FETCH_LO: begin
					iw_q <= fetch_word;
					// A taken jump replaces the advanced pointer.
					if (opcode == OP_JNZ && d_q != 8'd0) begin
						pc_q <= ADDR_W'(a_q) + operand[ADDR_W-1:0];
					end else begin
						pc_q <= pc_q + ADDR_W'(2);
					end
					if (opcode != OP_LDM && opcode != OP_STR) a_q <= alu;
					case (opcode)
						OP_SWB: b_q <= a_q;
						OP_SWC: c_q <= a_q;
						OP_SWD: d_q <= a_q;
						OP_SWE: e_q <= a_q;
						OP_HLT: halt_q <= 1'b1;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// Upper byte of the instruction word is held between the two fetches.
	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH_HI) hi_q <= mem_rdata;
	end

	// Result view of the registers.
	always_comb begin
		res.reg_a        = a_q;
		res.reg_b        = b_q;
		res.reg_c        = c_q;
		res.reg_d        = d_q;
		res.reg_e        = e_q;
		res.instr_ptr    = pc_q;
		res.halted       = halt_q;
		res.last_opcode  = iw_q[15:12];
		res.last_operand = iw_q[11:0];
		res.read_data    = rd_q;
	end

endmodule

// ----- rtl/accumulator_cpu_8bit_step.sv -----
// ----------------------------------------------------------------------------
// accumulator_cpu_8bit_step
// 8-bit accumulator CPU driven by memory write, memory read and step beats.
//
//   Channel | Direction | Payload
//   s_*     | in        | command [1:0], address [13:2], write_data [21:14]
//   m_*     | out       | registers, ip, halted, last word, read_data
//
// Writes, halted steps and unknown commands go straight to result; a read
// passes the read state, a step both fetch states and, for a memory load,
// the load state. Every access goes through the single memory port. After
// reset the memory is cleared; s_tready stays low until that pass ends.
// An input buffer and output register take a beat while a result is held.
// ----------------------------------------------------------------------------
module accumulator_cpu_8bit_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// command, address, write_data, zero pad
	input  logic [acs_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// reg_a, reg_b, reg_c, reg_d, reg_e, instr_ptr, halted, last_opcode,
	// last_operand, read_data, zero pad
	output logic [acs_pkg::M_TDATA_W-1:0] m_tdata
);
	import acs_pkg::*;

	localparam int ITEM_W = $bits(cmd_item_t);
	localparam int RES_W  = $bits(result_t);

	logic              buf_valid_q;
	cmd_item_t         buf_q;
	logic              out_valid_q;
	result_t           out_q;
	core_ctl_t         ctl;
	result_t           res;
	logic              out_free;
	logic              accept;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [7:0]        mem_wdata;
	logic [7:0]        mem_rdata;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !ctl.clearing && (!buf_valid_q || ctl.take);
	assign accept   = s_tvalid && s_tready;

	// Input beat buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
		end else begin
			buf_valid_q <= accept || (buf_valid_q && !ctl.take);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) buf_q <= cmd_item_t'(s_tdata[ITEM_W-1:0]);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(M_TDATA_W - RES_W)'(0), out_q};

	acs_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (buf_q),
		.item_valid (buf_valid_q),
		.out_free   (out_free),
		.ctl        (ctl),
		.res        (res),
		.mem_we     (mem_we),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata)
	);

	acs_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule

// ----- rtl/acs_checker.sv -----
// ----------------------------------------------------------------------------
// acs_checker
// Port-level checks for the accumulator CPU step block, bound to the top.
// ----------------------------------------------------------------------------
`include "accumulator_cpu_8bit_step_macros.svh"

module acs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [acs_pkg::S_TDATA_W-1:0] s_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [acs_pkg::M_TDATA_W-1:0] m_tdata
);
	import acs_pkg::*;

	localparam int HALT_BIT = 52;

	logic [1:0] count_q;
	logic       halt_seen_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	// Beats inside the block: input buffer, sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			halt_seen_q <= 1'b0;
		end else begin
			count_q <= count_q + 2'(in_beat) - 2'(out_beat);
			if (out_beat && m_tdata[HALT_BIT]) halt_seen_q <= 1'b1;
		end
	end

	// A stalled result beat keeps its payload.
	`ACS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

	// Every result beat answers an accepted input beat.
	`ACS_ASSERT_IMP(a_out_has_in, m_tvalid, count_q != 2'd0, "result without input beat")

	// With all three places taken the input side must stall.
	`ACS_ASSERT_IMP(a_full_stall, count_q == 2'd3, !s_tready, "input accepted while full")

	// Once a halt is reported, later results stay halted.
	`ACS_ASSERT_IMP(a_halt_sticky, m_tvalid && halt_seen_q, m_tdata[HALT_BIT], "halt flag cleared")

	// The memory clear pass holds off input right after reset.
	`ACS_ASSERT_IMP(a_clear_stall, $past(count_q) == 2'd0 && $rose(arst_n), !s_tready, "input during clear")

endmodule

bind accumulator_cpu_8bit_step acs_checker u_acs_checker (.*);
